FILE: rtl/core/bce_loss_row_reduce_macros.svh
// Assertion macros for the row-reduced cross-entropy loss block.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef BCE_LOSS_ROW_REDUCE_MACROS_SVH
`define BCE_LOSS_ROW_REDUCE_MACROS_SVH

// same-cycle implication
`define BCE_ASSERT_IMPL(name, clock, rstn, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("bce: same-cycle check failed");

// next-cycle implication
`define BCE_ASSERT_NEXT(name, clock, rstn, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("bce: next-cycle check failed");

`endif

FILE: rtl/core/bce_pkg.sv
// Package for the row-reduced cross-entropy loss block: beat types, command and
// status structs, fixed-point constants and the log table generator.
// No dependencies.
package bce_pkg;

	localparam int DEF_LOG_TABLE_ENTRIES = 1024;
	localparam int DEF_SUM_WIDTH = 48;
	localparam int LOG_W = 24;

	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic [15:0] PW_RESET = 16'd256;
	localparam logic [47:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [63:0] BIG_LIMIT = 64'h0000_0080_0000_0000;

	typedef struct packed {
		logic [16:0] probability;
		logic [16:0] label;
		logic row_last;
	} in_item_t;

	typedef struct packed {
		logic signed [47:0] row_loss;
		logic saturated;
	} out_item_t;

	typedef struct packed {
		logic fill_wr;
		logic take;
		logic norm;
		logic pos;
		logic interp;
		logic nlog;
		logic term;
		logic acc;
		logic sel;
		logic fin_hi;
		logic fin_lo;
		logic fin_wmag;
		logic fin_res;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic fill_done;
		logic row_last;
	} stat_t;

	// shift-subtract quotient, elaboration use only
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// ln(1 + num/den) in Q0.24 via 2*atanh(f/(2+f)) series in Q0.30
	function automatic logic [23:0] ln1p_q24(logic [63:0] num, logic [63:0] den);
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] p;
		logic [63:0] acc;
		logic [63:0] k;
		y = udiv64(num << 30, (den << 1) + num);
		y2 = (y * y) >> 30;
		p = y;
		acc = y;
		k = 64'd3;
		for (int it = 0; it < 64; it++) begin
			if (p != 64'd0) begin
				p = (p * y2) >> 30;
				acc = acc + udiv64(p, k);
				k = k + 64'd2;
			end
		end
		return 24'(((acc << 1) + 64'd32) >> 6);
	endfunction

	localparam logic [23:0] LN2_Q24 = ln1p_q24(64'd1, 64'd1);

endpackage

FILE: rtl/core/bce_loss_row_reduce.sv
// Row-reduced binary cross-entropy loss with positive weight, top level.
// Uses bce_pkg, bce_ctrl, bce_dpath and bce_ram.
// Input channel in_valid/in_stall/in_data carries one (probability, label,
// row_last) beat; the block raises in_stall while it works on a beat.
// Output channel out_valid/out_stall/out_data carries one (row_loss, saturated)
// beat per row, issued after the beat marked row_last.
// cfg_write/cfg_data write the Q8.8 positive weight (reset 1.0); write only
// while the block is idle.
// Each beat makes two passes through the one shared log unit (table RAM
// read, interpolation, term multiply, saturating add). A row_last beat adds
// weighting and result clamping (S_FIN1 to S_FIN4) and the output load
// (S_OUT) before the next beat is taken.
// After reset all LOG_TABLE_ENTRIES entries of the log table RAM (1024 by
// default) are filled with in_stall high; configuration writes are still taken.
// The result sits in an output register: a stalled receiver holds it while
// the next row is worked on; a new row result waits until it is taken.
module bce_loss_row_reduce #(
	parameter int LOG_TABLE_ENTRIES = bce_pkg::DEF_LOG_TABLE_ENTRIES,
	parameter int SUM_WIDTH = bce_pkg::DEF_SUM_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  bce_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output bce_pkg::out_item_t out_data
);

	bce_pkg::cmd_t cmd;
	bce_pkg::stat_t stat;

	bce_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat(stat),
		.cmd(cmd)
	);

	bce_dpath #(
		.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES),
		.SUM_WIDTH(SUM_WIDTH)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.cmd(cmd),
		.stat(stat),
		.out_data(out_data)
	);

endmodule

FILE: rtl/core/bce_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies beyond bce_pkg defaults.
module bce_ram #(
	parameter int WIDTH = bce_pkg::LOG_W,
	parameter int DEPTH = bce_pkg::DEF_LOG_TABLE_ENTRIES
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: rtl/core/bce_ctrl.sv
// Controller for the row-reduced cross-entropy loss block: table fill, two log
// passes per beat, row finish and output register handshake. Uses bce_pkg.
`include "bce_loss_row_reduce_macros.svh"

module bce_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  bce_pkg::stat_t stat,
	output bce_pkg::cmd_t  cmd
);

	typedef enum logic [13:0] {
		S_FILL   = 14'h0001,
		S_IDLE   = 14'h0002,
		S_NORM   = 14'h0004,
		S_POS    = 14'h0008,
		S_READ   = 14'h0010,
		S_INTERP = 14'h0020,
		S_NLOG   = 14'h0040,
		S_TERM   = 14'h0080,
		S_ACC    = 14'h0100,
		S_FIN1   = 14'h0200,
		S_FIN2   = 14'h0400,
		S_FIN3   = 14'h0800,
		S_FIN4   = 14'h1000,
		S_OUT    = 14'h2000
	} state_t;

	state_t state_q, state_d;
	logic sel_q, sel_d;
	logic out_valid_q, out_valid_d;

	always_comb begin
		cmd = '0;
		cmd.sel = sel_q;
		state_d = state_q;
		sel_d = sel_q;
		case (state_q)
			S_FILL: begin
				cmd.fill_wr = 1'b1;
				if (stat.fill_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					sel_d = 1'b0;
					state_d = S_NORM;
				end
			end
			S_NORM: begin
				cmd.norm = 1'b1;
				state_d = S_POS;
			end
			S_POS: begin
				cmd.pos = 1'b1;
				state_d = S_READ;
			end
			S_READ: begin
				state_d = S_INTERP;
			end
			S_INTERP: begin
				cmd.interp = 1'b1;
				state_d = S_NLOG;
			end
			S_NLOG: begin
				cmd.nlog = 1'b1;
				state_d = S_TERM;
			end
			S_TERM: begin
				cmd.term = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (!sel_q) begin
					sel_d = 1'b1;
					state_d = S_NORM;
				end else if (stat.row_last) begin
					state_d = S_FIN1;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FIN1: begin
				cmd.fin_hi = 1'b1;
				state_d = S_FIN2;
			end
			S_FIN2: begin
				cmd.fin_lo = 1'b1;
				state_d = S_FIN3;
			end
			S_FIN3: begin
				cmd.fin_wmag = 1'b1;
				state_d = S_FIN4;
			end
			S_FIN4: begin
				cmd.fin_res = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (cmd.load_out) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
			sel_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q <= sel_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	`BCE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`BCE_ASSERT_IMPL(a_no_overwrite, clk, arst_n, cmd.load_out, !out_valid || !out_stall)
	`BCE_ASSERT_NEXT(a_drain, clk, arst_n, out_valid && !out_stall && !cmd.load_out, !out_valid)

endmodule

FILE: rtl/core/bce_dpath.sv
// Datapath for the row-reduced cross-entropy loss block: log unit with table
// RAM, term multiply, saturating sums and weighted row result.
// Uses bce_pkg and bce_ram.
module bce_dpath #(
	parameter int LOG_TABLE_ENTRIES = bce_pkg::DEF_LOG_TABLE_ENTRIES,
	parameter int SUM_WIDTH = bce_pkg::DEF_SUM_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [15:0]         cfg_data,
	input  bce_pkg::in_item_t   in_data,
	input  bce_pkg::cmd_t       cmd,
	output bce_pkg::stat_t      stat,
	output bce_pkg::out_item_t  out_data
);

	localparam int SW = SUM_WIDTH;
	localparam int AW = $clog2(LOG_TABLE_ENTRIES);
	localparam int EW = $clog2(LOG_TABLE_ENTRIES + 1);
	localparam int POS_W = 16 + EW;
	localparam int MH_W = (SW > 32) ? SW - 32 : 1;
	localparam int HI_W = MH_W + 16;
	localparam int HT_W = (HI_W < 39) ? HI_W : 39;
	localparam int WM_W = (((HT_W + 24) > 41) ? HT_W + 24 : 41) + 1;
	localparam int CW = ((WM_W > SW) ? WM_W : SW) + 1;
	localparam int RW = (SW > 48) ? SW : 48;

	localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic [SW-1:0] SUM_MAX_U = {1'b0, {(SW-1){1'b1}}};
	localparam logic [AW-1:0] LAST_IDX = AW'(LOG_TABLE_ENTRIES - 1);

	// constant log table, copied into the RAM by the fill sweep
	logic [23:0] rom_w [LOG_TABLE_ENTRIES];
	for (genvar g = 0; g < LOG_TABLE_ENTRIES; g++) begin : g_rom
		localparam logic [23:0] ROM_VAL =
			bce_pkg::ln1p_q24(64'(g), 64'(LOG_TABLE_ENTRIES));
		assign rom_w[g] = ROM_VAL;
	end

	logic [AW-1:0] fill_cnt_q;
	logic [15:0] pw_q;
	logic signed [SW-1:0] neg_sum_q, pos_sum_q;
	logic ovf_q;

	logic [16:0] xq_q, xp_q, yneg_q, ypos_q;
	logic last_q;
	logic [4:0] sh_q;
	logic [15:0] frac_q;
	logic [AW-1:0] idx_q;
	logic [15:0] w_q;
	logic top_q;
	logic [28:0] whole_q;
	logic [39:0] prod_q;
	logic [23:0] lo_q;
	logic [20:0] nl_q;
	logic [20:0] mag_q;
	logic [HI_W-1:0] hi_q;
	logic [47:0] lom_q;
	logic big_q;
	logic [WM_W-1:0] wmag_q;
	logic [47:0] res_q;
	logic rsat_q;
	bce_pkg::out_item_t out_q;

	logic [23:0] rd_lo, rd_hi;
	logic [AW-1:0] idx_next;

	assign idx_next = idx_q + AW'(1);

	bce_ram #(
		.WIDTH(bce_pkg::LOG_W),
		.DEPTH(LOG_TABLE_ENTRIES)
	) u_log_ram (
		.clk(clk),
		.we(cmd.fill_wr),
		.waddr(fill_cnt_q),
		.wdata(rom_w[fill_cnt_q]),
		.raddr_a(idx_q),
		.raddr_b(idx_next),
		.rdata_a(rd_lo),
		.rdata_b(rd_hi)
	);

	assign stat.fill_done = (fill_cnt_q == LAST_IDX);
	assign stat.row_last = last_q;

	// input clamp
	logic [16:0] p_c, y_c, q_c;
	always_comb begin
		p_c = (in_data.probability > bce_pkg::ONE_Q16) ? bce_pkg::ONE_Q16 : in_data.probability;
		y_c = (in_data.label > bce_pkg::ONE_Q16) ? bce_pkg::ONE_Q16 : in_data.label;
		q_c = bce_pkg::ONE_Q16 - p_c;
	end

	// normalise
	logic [16:0] x_n, x_sh;
	logic [4:0] e_n, sh_n;
	always_comb begin
		x_n = cmd.sel ? xp_q : xq_q;
		e_n = '0;
		for (int b = 0; b < 17; b++) begin
			if (x_n[b]) begin
				e_n = 5'(b);
			end
		end
		sh_n = 5'd16 - e_n;
		x_sh = x_n << sh_n;
	end

	logic [POS_W-1:0] pos_n;
	assign pos_n = POS_W'(frac_q) * POS_W'(LOG_TABLE_ENTRIES);

	logic [23:0] hi_sel;
	assign hi_sel = top_q ? bce_pkg::LN2_Q24 : rd_hi;

	logic [23:0] interp_n;
	logic [28:0] nl_full;
	assign interp_n = lo_q + 24'((41'(prod_q) + 41'd32768) >> 16);
	assign nl_full = (whole_q - 29'(interp_n) + 29'd128) >> 8;

	logic [38:0] tprod;
	assign tprod = 39'(cmd.sel ? ypos_q : yneg_q) * 39'(nl_q);

	// saturating accumulate, shared by both sums
	logic signed [SW-1:0] acc_s, acc_r;
	logic signed [SW:0] acc_t, acc_x;
	logic acc_ovf;
	always_comb begin
		acc_s = cmd.sel ? pos_sum_q : neg_sum_q;
		acc_t = signed'((SW+1)'(mag_q));
		if (cmd.sel) begin
			acc_t = -acc_t;
		end
		acc_x = (SW+1)'(acc_s) + acc_t;
		acc_ovf = 1'b0;
		if (acc_x > (SW+1)'(SUM_MAX)) begin
			acc_r = SUM_MAX;
			acc_ovf = 1'b1;
		end else if (acc_x < (SW+1)'(SUM_MIN)) begin
			acc_r = SUM_MIN;
			acc_ovf = 1'b1;
		end else begin
			acc_r = SW'(acc_x);
		end
	end

	// row finish
	logic [SW-1:0] pmag;
	logic [31+MH_W:0] pmag_x;
	logic [40:0] lo_rnd;
	logic [SW-1:0] neg_u, res_u;
	logic [CW-1:0] total;
	logic fin_sat, clamp;
	always_comb begin
		pmag = pos_sum_q[SW-1] ? (SW'(0) - unsigned'(pos_sum_q)) : '0;
		pmag_x = (32+MH_W)'(pmag);
		lo_rnd = 41'((49'(lom_q) + 49'd128) >> 8);
		neg_u = neg_sum_q[SW-1] ? '0 : unsigned'(neg_sum_q);
		total = CW'(neg_u) + CW'(wmag_q);
		fin_sat = big_q || (CW'(wmag_q) > CW'(SUM_MAX_U)) || (total > CW'(SUM_MAX_U));
		res_u = fin_sat ? SUM_MAX_U : SW'(total);
		clamp = RW'(res_u) > RW'(bce_pkg::OUT_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q <= '0;
			pw_q <= bce_pkg::PW_RESET;
			neg_sum_q <= '0;
			pos_sum_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.fill_wr) begin
				fill_cnt_q <= fill_cnt_q + AW'(1);
			end
			if (cfg_write) begin
				pw_q <= cfg_data;
			end
			if (cmd.acc) begin
				if (cmd.sel) begin
					pos_sum_q <= acc_r;
				end else begin
					neg_sum_q <= acc_r;
				end
				ovf_q <= ovf_q | acc_ovf;
			end else if (cmd.load_out) begin
				neg_sum_q <= '0;
				pos_sum_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			xq_q <= (q_c == 17'd0) ? 17'd1 : q_c;
			xp_q <= (p_c == 17'd0) ? 17'd1 : p_c;
			yneg_q <= bce_pkg::ONE_Q16 - y_c;
			ypos_q <= y_c;
			last_q <= in_data.row_last;
		end
		if (cmd.norm) begin
			sh_q <= sh_n;
			frac_q <= x_sh[15:0];
		end
		if (cmd.pos) begin
			idx_q <= AW'(pos_n[POS_W-1:16]);
			w_q <= pos_n[15:0];
			top_q <= (AW'(pos_n[POS_W-1:16]) == LAST_IDX);
			whole_q <= 29'(sh_q) * 29'(bce_pkg::LN2_Q24);
		end
		if (cmd.interp) begin
			prod_q <= 40'(hi_sel - rd_lo) * 40'(w_q);
			lo_q <= rd_lo;
		end
		if (cmd.nlog) begin
			nl_q <= nl_full[20:0];
		end
		if (cmd.term) begin
			mag_q <= 21'((tprod + 39'd32768) >> 16);
		end
		if (cmd.fin_hi) begin
			hi_q <= HI_W'(pmag_x[31+MH_W:32]) * HI_W'(pw_q);
		end
		if (cmd.fin_lo) begin
			lom_q <= 48'(pmag_x[31:0]) * 48'(pw_q);
		end
		if (cmd.fin_wmag) begin
			big_q <= (64'(hi_q) >= bce_pkg::BIG_LIMIT);
			wmag_q <= WM_W'({hi_q[HT_W-1:0], 24'd0}) + WM_W'(lo_rnd);
		end
		if (cmd.fin_res) begin
			res_q <= clamp ? bce_pkg::OUT_MAX : 48'(res_u);
			rsat_q <= fin_sat | clamp | ovf_q;
		end
		if (cmd.load_out) begin
			out_q.row_loss <= signed'(res_q);
			out_q.saturated <= rsat_q;
		end
	end

	assign out_data = out_q;

endmodule

FILE: test/bce_loss_row_reduce_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for bce_loss_row_reduce: a driver and a monitor around the
// block, with an in-bench row loss predictor and its own log ROM. Needs bce_pkg.
module bce_loss_row_reduce_tb;

	localparam int ROM_DEPTH = bce_pkg::DEF_LOG_TABLE_ENTRIES;
	localparam longint SUM_MAX = (64'sd1 <<< (bce_pkg::DEF_SUM_WIDTH - 1)) - 1;
	localparam int STALL_LIMIT = 6000;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE = 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	bce_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	bce_pkg::out_item_t out_data;

	logic [23:0] ln_rom [ROM_DEPTH];
	logic [23:0] ln2_q24;
	logic [15:0] weight_q8_8 = bce_pkg::PW_RESET;
	longint neg_sum = 0;
	longint pos_sum = 0;
	bit sum_overflow = 1'b0;

	bce_pkg::in_item_t beats_to_send[$];
	bce_pkg::out_item_t row_results_due[$];
	bce_pkg::out_item_t row_want;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int fail_count = 0;
	int idle_cycles = 0;
	int holds_asked = 0;
	int holds_done = 0;
	int hold_left = 0;

	bce_loss_row_reduce DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ln(1 + num/den), Q0.24, from the atanh series in Q0.30
	function automatic logic [23:0] ln_entry(longint unsigned num, longint unsigned den);
		longint unsigned z;
		longint unsigned z2;
		longint unsigned pw;
		longint unsigned acc;
		longint unsigned k;
		z = (num << 30) / (2 * den + num);
		z2 = (z * z) >> 30;
		pw = z;
		acc = z;
		for (k = 3; pw != 0; k += 2) begin
			pw = (pw * z2) >> 30;
			acc += pw / k;
		end
		return 24'((2 * acc + 64'd32) >> 6);
	endfunction

	// -ln(x/65536) in Q.16, x in [1, 65536]
	function automatic longint unsigned neg_ln_q16(logic [16:0] x);
		int e;
		int idx;
		longint unsigned frac;
		longint unsigned posn;
		longint unsigned w;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned interp;
		longint unsigned whole;
		e = 16;
		while (e > 0 && !x[e])
			e--;
		frac = (64'(x) << (16 - e)) - 64'd65536;
		posn = frac * ROM_DEPTH;
		idx = int'(posn >> 16);
		w = posn & 64'hFFFF;
		if (idx >= ROM_DEPTH)
			idx = ROM_DEPTH - 1;
		lo = ln_rom[idx];
		hi = (idx + 1 < ROM_DEPTH) ? ln_rom[idx + 1] : ln2_q24;
		interp = lo + (((hi - lo) * w + 64'd32768) >> 16);
		whole = 64'(16 - e) * ln2_q24;
		return (whole - interp + 64'd128) >> 8;
	endfunction

	function automatic longint sat_sum(longint s, longint t);
		if (t > 0 && s > SUM_MAX - t) begin
			sum_overflow = 1'b1;
			return SUM_MAX;
		end
		if (t < 0 && s < -SUM_MAX - 1 - t) begin
			sum_overflow = 1'b1;
			return -SUM_MAX - 1;
		end
		return s + t;
	endfunction

	task automatic accumulate_beat(bce_pkg::in_item_t beat);
		logic [16:0] p;
		logic [16:0] y;
		longint unsigned q;
		longint unsigned nl1;
		longint unsigned nl0;
		longint unsigned nmag;
		longint unsigned pmag;
		longint unsigned mag;
		longint unsigned hi;
		longint unsigned lo;
		longint unsigned wmag;
		longint unsigned negv;
		longint res;
		bit sat;
		bce_pkg::out_item_t r;
		p = beat.probability > bce_pkg::ONE_Q16 ? bce_pkg::ONE_Q16 : beat.probability;
		y = beat.label > bce_pkg::ONE_Q16 ? bce_pkg::ONE_Q16 : beat.label;
		q = 64'd65536 - p;
		nl1 = neg_ln_q16(q == 0 ? 17'd1 : 17'(q));
		nl0 = neg_ln_q16(p == 0 ? 17'd1 : p);
		nmag = ((64'd65536 - y) * nl1 + 64'd32768) >> 16;
		pmag = (64'(y) * nl0 + 64'd32768) >> 16;
		neg_sum = sat_sum(neg_sum, longint'(nmag));
		pos_sum = sat_sum(pos_sum, -longint'(pmag));
		if (!beat.row_last)
			return;
		sat = 1'b0;
		mag = pos_sum < 0 ? 64'(-pos_sum) : 64'd0;
		hi = (mag >> 32) * weight_q8_8;
		lo = (mag & 64'hFFFF_FFFF) * weight_q8_8;
		negv = neg_sum > 0 ? 64'(neg_sum) : 64'd0;
		if (hi >= bce_pkg::BIG_LIMIT) begin
			sat = 1'b1;
			res = SUM_MAX;
		end else begin
			wmag = (hi << 24) + ((lo + 64'd128) >> 8);
			if (wmag > SUM_MAX || negv > SUM_MAX - wmag) begin
				sat = 1'b1;
				res = SUM_MAX;
			end else begin
				res = longint'(negv + wmag);
			end
		end
		if (res > longint'(bce_pkg::OUT_MAX)) begin
			res = longint'(bce_pkg::OUT_MAX);
			sat = 1'b1;
		end
		r.row_loss = res[47:0];
		r.saturated = sum_overflow | sat;
		row_results_due.push_back(r);
		neg_sum = 0;
		pos_sum = 0;
		sum_overflow = 1'b0;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				accumulate_beat(in_data);
			if (!in_valid || !in_stall) begin
				if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data <= beats_to_send.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (row_results_due.size() == 0) begin
					$display("%0t: unexpected row result, loss %0d sat %0b", $time,
						out_data.row_loss, out_data.saturated);
					fail_count++;
				end else begin
					row_want = row_results_due.pop_front();
					if (out_data.row_loss !== row_want.row_loss) begin
						$display("%0t: row_loss expected %0d got %0d", $time,
							row_want.row_loss, out_data.row_loss);
						fail_count++;
					end
					if (out_data.saturated !== row_want.saturated) begin
						$display("%0t: saturated expected %0b got %0b", $time,
							row_want.saturated, out_data.saturated);
						fail_count++;
					end
				end
			end
			if (holds_asked != holds_done) begin
				holds_done <= holds_asked;
				hold_left <= LONG_HOLD;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= $urandom_range(99) < recv_stall_pct;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
			$display("bce_loss_row_reduce_tb failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [16:0] rand_q16(int hard_pct);
		int pick;
		pick = $urandom_range(99);
		if (pick < hard_pct)
			return $urandom_range(1) ? 17'd0 : bce_pkg::ONE_Q16;
		if (pick < hard_pct + 6)
			return 17'($urandom_range(131071, 65537));
		if (pick < hard_pct + 14)
			return $urandom_range(1) ? 17'($urandom_range(2)) : 17'(65536 - $urandom_range(2));
		return 17'($urandom_range(65536));
	endfunction

	task automatic add_beat(logic [16:0] p, logic [16:0] y, logic last);
		bce_pkg::in_item_t b;
		b.probability = p;
		b.label = y;
		b.row_last = last;
		beats_to_send.push_back(b);
	endtask

	task automatic queue_rows(int count, int longest);
		int left;
		int len;
		left = count;
		while (left > 0) begin
			len = $urandom_range(longest, 1);
			if (len > left)
				len = left;
			for (int k = 0; k < len; k++)
				add_beat(rand_q16(0), rand_q16(30), k == len - 1);
			left -= len;
		end
	endtask

	task automatic settle();
		while (beats_to_send.size() != 0 || in_valid || row_results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_weight(logic [15:0] v);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		weight_q8_8 = v;
	endtask

	task automatic run_phase(int items, int longest, int send_pct, int recv_pct,
		logic [15:0] w);
		settle();
		write_weight(w);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		queue_rows(items, longest);
	endtask

	initial begin
		for (int i = 0; i < ROM_DEPTH; i++)
			ln_rom[i] = ln_entry(i, ROM_DEPTH);
		ln2_q24 = ln_entry(1, 1);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		write_weight(16'd256);
		@(negedge clk);
		// log of zero, probability and label at and above one
		add_beat(17'd0, 17'd0, 1'b1);
		add_beat(17'd0, 17'd65536, 1'b1);
		add_beat(17'd65536, 17'd0, 1'b1);
		add_beat(17'd65536, 17'd65536, 1'b1);
		add_beat(17'd131071, 17'd131071, 1'b1);
		add_beat(17'd65537, 17'd0, 1'b1);
		add_beat(17'd0, 17'd65537, 1'b1);
		add_beat(17'd32768, 17'd32768, 1'b0);
		add_beat(17'd1, 17'd65535, 1'b0);
		add_beat(17'd65535, 17'd1, 1'b1);
		add_beat(17'd0, 17'd65536, 1'b0);
		add_beat(17'd1, 17'd0, 1'b0);
		add_beat(17'd2, 17'd65536, 1'b0);
		add_beat(17'd65534, 17'd32768, 1'b0);
		add_beat(17'd65535, 17'd65536, 1'b1);
		add_beat(17'd1024, 17'd65536, 1'b1);
		add_beat(17'd4096, 17'd0, 1'b1);
		add_beat(17'd98304, 17'd12345, 1'b1);
		add_beat(17'd45000, 17'd131071, 1'b1);
		add_beat(17'd20000, 17'd50000, 1'b1);

		run_phase(250, 12, 0, 0, 16'hFFFF);
		run_phase(250, 12, 49, 0, 16'd0);
		run_phase(250, 12, 0, 49, 16'($urandom_range(65535)));
		// receiver holds off while short rows keep coming
		run_phase(100, 3, 0, 0, 16'd256);
		holds_asked++;
		run_phase(250, 12, 9, 9, 16'($urandom_range(65535)));
		run_phase(150, 6, 0, 0, 16'd1);
		settle();

		if (fail_count == 0 && row_results_due.size() == 0)
			$display("bce_loss_row_reduce_tb passed");
		else
			$display("bce_loss_row_reduce_tb failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/bce_pkg.sv
rtl/core/bce_ram.sv
rtl/core/bce_ctrl.sv
rtl/core/bce_dpath.sv
rtl/core/bce_loss_row_reduce.sv
test/bce_loss_row_reduce_tb.sv
